// ----- rtl/copying_garbage_collector_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the copying garbage collector
// ---------------------------------------------------------------------------
`ifndef COPYING_GARBAGE_COLLECTOR_MACROS_SVH
`define COPYING_GARBAGE_COLLECTOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CGC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/cgc_pkg.sv -----
// ---------------------------------------------------------------------------
// cgc_pkg: shared constants and types
// Holds sizes, command codes and field helpers of the collector.
// ---------------------------------------------------------------------------
package cgc_pkg;
  localparam int HeapWords = 4096;
  localparam int RootSlots = 256;
  localparam int HwW = 13;
  localparam int HiW = 12;
  localparam int RsW = 8;
  localparam int FreeW = 17;

  typedef enum logic [2:0] {
    CMD_WR_HEAP  = 3'd0,
    CMD_RD_HEAP  = 3'd1,
    CMD_WR_ROOT  = 3'd2,
    CMD_RD_ROOT  = 3'd3,
    CMD_COLLECT  = 3'd4
  } cmd_e;

  // True when byte address lies inside the given space. A space spans
  // HeapWords words, so bit HiW+3 of the byte address selects the space.
  function automatic logic in_space(input logic [63:0] a, input logic sp);
    in_space = (a[63:HiW+4] == '0) && (a[HiW+3] == sp);
  endfunction
endpackage

// ----- rtl/cgc_ram.sv -----
// ---------------------------------------------------------------------------
// cgc_ram: single-port synchronous RAM
// One read or write per cycle, registered read data.
// ---------------------------------------------------------------------------
module cgc_ram #(
  parameter int Depth = 8192,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [63:0]      wdata_i,
  output logic [63:0]      rdata_o
);
  logic [63:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- rtl/copying_garbage_collector.sv -----
// ---------------------------------------------------------------------------
// copying_garbage_collector: Cheney copying collector over two semispaces
// After reset the block first clears both RAMs, one heap word and one root
// slot a cycle, before it takes a beat. A host read then goes through the
// RAM read, the result, and a turnaround back in idle before the next beat
// is taken; a write or an unknown command skips the RAM read. The heap and
// root RAMs each have a single port, so each read of a collect is followed
// by a state that uses or writes the read data. A collect reads each root,
// scans each tuple in tospace element by element with a read per pointer
// element, moves each reachable tuple word by word while tospace has room
// and forwards its old tag, and ends with a sweep that clears the old space.
// Results sit in an output register, so the next command beat is taken
// while a result still waits.
// ---------------------------------------------------------------------------
`include "copying_garbage_collector_macros.svh"

module copying_garbage_collector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [12:0] heap_word_i,
  input  logic [7:0]  root_slot_i,
  input  logic [8:0]  root_count_i,
  input  logic signed [63:0] write_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [63:0] read_value_o,
  output logic [16:0] free_address_o,
  output logic        active_space_o,
  output logic        status_o
);
  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_HRD, S_RRD, S_DONE,
    S_ROOT, S_ROOT_W, S_MOVE, S_MOVE_W,
    S_CPY, S_CPY_W, S_FWD, S_SCAN, S_SCAN_W, S_ELEM, S_ELEM_W,
    S_ZAP, S_FIN
  } state_e;

  state_e state_q;
  logic        h_we, r_we;
  logic [12:0] h_addr;
  logic [7:0]  r_addr;
  logic [63:0] h_wd, r_wd, h_rd, r_rd;

  cgc_ram #(.Depth(8192)) u_heap (.clk_i, .we_i(h_we), .addr_i(h_addr),
    .wdata_i(h_wd), .rdata_o(h_rd));
  cgc_ram #(.Depth(256)) u_root (.clk_i, .we_i(r_we), .addr_i(r_addr),
    .wdata_i(r_wd), .rdata_o(r_rd));

  // Collector registers. Word indices are 13 bits (both spaces).
  logic        live_q, ovf_q, busy_q;
  logic [16:0] free_q;
  logic [12:0] clr_q;
  logic [8:0]  rcnt_q, ridx_q;
  logic [13:0] alloc_q, scan_q;   // one extra bit so the end of space 1 fits
  logic [12:0] src_q, cpy_q;
  logic [6:0]  words_q, k_q;
  logic [63:0] tag_q;
  logic [5:0]  len_q, ei_q;
  logic        from_root_q;       // referring word is a root, else heap
  logic [12:0] refa_q;            // address of the referring word
  logic [2:0]  cmd_q;
  logic [12:0] hw_q;
  logic [7:0]  rs_q;
  logic [63:0] wv_q;
  logic        ov_q;
  logic [63:0] rv_q;
  // Pending write of the referring word, issued in S_FIN.
  logic        rw_pend_q;
  logic [63:0] rw_val_q;

  wire accept  = in_valid_i && !in_stall_o;
  wire out_free = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || busy_q;

  wire [13:0] to_end  = {1'b0, !live_q, 12'd0} + 14'(cgc_pkg::HeapWords);
  wire [13:0] fr_end  = {1'b0, live_q, 12'd0} + 14'(cgc_pkg::HeapWords);

  // RAM port control
  always_comb begin
    h_we = 1'b0; r_we = 1'b0;
    h_addr = hw_q; r_addr = rs_q;
    h_wd = wv_q; r_wd = wv_q;
    case (state_q)
      S_CLR: begin
        h_we = 1'b1; h_addr = clr_q; h_wd = '0;
        r_we = 1'b1; r_addr = clr_q[7:0]; r_wd = '0;
      end
      S_IDLE: begin
        h_addr = heap_word_i; r_addr = root_slot_i;
        if (accept && cmd_i == cgc_pkg::CMD_WR_HEAP) begin
          h_we = 1'b1; h_wd = write_value_i;
        end
        if (accept && cmd_i == cgc_pkg::CMD_WR_ROOT) begin
          r_we = 1'b1; r_wd = write_value_i;
        end
      end
      S_ROOT:  r_addr = ridx_q[7:0];
      S_MOVE:  h_addr = src_q;
      S_CPY:   h_addr = src_q + 13'(k_q);
      S_CPY_W: begin
        h_we = 1'b1; h_addr = cpy_q;
        h_wd = ({1'b0, src_q} + 14'(k_q) < fr_end) ? h_rd : '0;
      end
      S_FWD: begin
        // Forward the old tag to the copy.
        h_we = 1'b1; h_addr = src_q; h_wd = {48'd0, alloc_q[12:0], 3'd1};
      end
      S_SCAN: h_addr = scan_q[12:0];
      S_ELEM: h_addr = scan_q[12:0] + 13'd1 + 13'(ei_q);
      S_ZAP: begin
        h_we = 1'b1; h_addr = {live_q, clr_q[11:0]}; h_wd = '0;
      end
      S_FIN: begin
        // Write the new value of the referring word, root or heap element.
        if (rw_pend_q && from_root_q) begin
          r_we = 1'b1; r_addr = refa_q[7:0]; r_wd = rw_val_q;
        end
        if (rw_pend_q && !from_root_q) begin
          h_we = 1'b1; h_addr = refa_q; h_wd = rw_val_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; live_q <= 1'b0; free_q <= '0;
      ov_q <= 1'b0; busy_q <= 1'b0; rw_pend_q <= 1'b0; rw_val_q <= '0;
      ovf_q <= 1'b0; rcnt_q <= '0; ridx_q <= '0; alloc_q <= '0; scan_q <= '0;
      src_q <= '0; cpy_q <= '0; words_q <= '0; k_q <= '0; tag_q <= '0;
      len_q <= '0; ei_q <= '0; from_root_q <= 1'b0; refa_q <= '0;
      cmd_q <= '0; hw_q <= '0; rs_q <= '0; wv_q <= '0; rv_q <= '0;
      read_value_o <= '0; free_address_o <= '0; active_space_o <= 1'b0;
      status_o <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 13'd1;
          if (clr_q == 13'h1FFF) state_q <= S_IDLE;
        end
        S_IDLE: begin
          busy_q <= accept;
          if (accept) begin
            cmd_q <= cmd_i; hw_q <= heap_word_i; rs_q <= root_slot_i;
            wv_q <= write_value_i;
            case (cmd_i)
              cgc_pkg::CMD_RD_HEAP: state_q <= S_HRD;
              cgc_pkg::CMD_RD_ROOT: state_q <= S_RRD;
              cgc_pkg::CMD_COLLECT: begin
                rcnt_q <= (root_count_i > 9'(cgc_pkg::RootSlots)) ?
                          9'(cgc_pkg::RootSlots) : root_count_i;
                ridx_q <= '0; ovf_q <= 1'b0;
                alloc_q <= {1'b0, !live_q, 12'd0};
                scan_q <= {1'b0, !live_q, 12'd0};
                state_q <= S_ROOT;
              end
              default: begin rv_q <= '0; state_q <= S_DONE; end
            endcase
          end
        end
        S_HRD: begin rv_q <= h_rd; state_q <= S_DONE; end
        S_RRD: begin rv_q <= r_rd; state_q <= S_DONE; end
        S_DONE: if (out_free) begin
          read_value_o <= rv_q;
          free_address_o <= free_q; active_space_o <= live_q;
          status_o <= (cmd_q == cgc_pkg::CMD_COLLECT) ? ovf_q : 1'b0;
          state_q <= S_IDLE;
        end
        S_ROOT: begin
          if (ridx_q >= rcnt_q || ovf_q) state_q <= S_SCAN;
          else state_q <= S_ROOT_W;
        end
        S_ROOT_W: begin
          ridx_q <= ridx_q + 9'd1;
          if (r_rd != 64'd0 && cgc_pkg::in_space(r_rd, live_q)) begin
            src_q <= r_rd[15:3]; from_root_q <= 1'b1;
            refa_q <= 13'(ridx_q[7:0]); state_q <= S_MOVE;
          end else state_q <= S_ROOT;
        end
        S_MOVE: state_q <= S_MOVE_W;
        S_MOVE_W: begin
          words_q <= 7'(h_rd[6:1]) + 7'd1; k_q <= '0; cpy_q <= alloc_q[12:0];
          if (h_rd[0]) begin
            rw_val_q <= {h_rd[63:1], 1'b0}; rw_pend_q <= 1'b1;
            state_q <= S_FIN;
          end else if (alloc_q + 14'(h_rd[6:1]) + 14'd1 > to_end) begin
            ovf_q <= 1'b1; state_q <= S_FIN;
          end else state_q <= S_CPY;
        end
        S_CPY: state_q <= S_CPY_W;
        S_CPY_W: begin
          k_q <= k_q + 7'd1; cpy_q <= cpy_q + 13'd1;
          state_q <= (k_q + 7'd1 == words_q) ? S_FWD : S_CPY;
        end
        S_FWD: begin
          rw_val_q <= {48'd0, alloc_q[12:0], 3'd0}; rw_pend_q <= 1'b1;
          alloc_q <= alloc_q + 14'(words_q);
          state_q <= S_FIN;
        end
        S_FIN: begin
          // A pending write of the referring word is issued this cycle; a heap element
          // then moves on to the next element of the scanned tuple.
          rw_pend_q <= 1'b0;
          if (!from_root_q) ei_q <= ei_q + 6'd1;
          state_q <= from_root_q ? S_ROOT : S_ELEM;
        end
        S_SCAN: begin
          if (ovf_q || scan_q >= alloc_q) begin
            clr_q <= '0; state_q <= S_ZAP;
          end else state_q <= S_SCAN_W;
        end
        S_SCAN_W: begin
          tag_q <= h_rd; len_q <= h_rd[6:1]; ei_q <= '0;
          state_q <= S_ELEM;
        end
        S_ELEM: begin
          if (ovf_q || ei_q >= len_q || ei_q > 6'd56) begin
            scan_q <= scan_q + 14'(len_q) + 14'd1; state_q <= S_SCAN;
          end else if (!tag_q[7 + ei_q]) begin
            ei_q <= ei_q + 6'd1;
          end else state_q <= S_ELEM_W;
        end
        S_ELEM_W: begin
          if (cgc_pkg::in_space(h_rd, live_q)) begin
            src_q <= h_rd[15:3]; from_root_q <= 1'b0;
            refa_q <= scan_q[12:0] + 13'd1 + 13'(ei_q); state_q <= S_MOVE;
          end else begin
            ei_q <= ei_q + 6'd1; state_q <= S_ELEM;
          end
        end
        S_ZAP: begin
          clr_q <= clr_q + 13'd1;
          if (clr_q[11:0] == 12'hFFF) begin
            live_q <= !live_q;
            free_q <= {alloc_q, 3'd0};
            state_q <= S_DONE; rv_q <= '0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;

  `CGC_ASSERT_IMP(a_stall_busy, clk_i, rst_ni, state_q != S_IDLE, in_stall_o)
  `CGC_ASSERT_NEXT(a_swap, clk_i, rst_ni,
    (state_q == S_ZAP && clr_q[11:0] == 12'hFFF), live_q != $past(live_q))
endmodule

// ----- verif/tb_copying_garbage_collector.sv -----
// ---------------------------------------------------------------------------
// tb_copying_garbage_collector: self-checking bench for the copying collector
// A short stimulus table and randomly built object graphs drive host heap and
// root accesses and collects; every result beat is compared with a scoreboard
// fed by hand-written rows or by a cycle-free model of the semispace copy.
// ---------------------------------------------------------------------------
module tb_copying_garbage_collector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CmdRsvdFirst = 3'd5;
  localparam logic [2:0] CmdRsvdLast = 3'd7;
  localparam int TargetBeats = 850;
  localparam int CycleLimit = 3000000;
  localparam int HoldCycles = 600;
  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] rd;
    logic [16:0] fa;
    logic        sp;
    logic        st;
  } gc_res_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [12:0] hw;
    logic [7:0]  rs;
    logic [8:0]  rc;
    logic [63:0] wv;
    logic        typed;
    gc_res_t     res;
  } beat_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] cmd;
  logic [12:0] heap_word;
  logic [7:0] root_slot;
  logic [8:0] root_count;
  logic signed [63:0] write_value, read_value;
  logic [16:0] free_address;
  logic active_space, status;

  copying_garbage_collector u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .heap_word_i(heap_word), .root_slot_i(root_slot),
    .root_count_i(root_count), .write_value_i(write_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .read_value_o(read_value), .free_address_o(free_address),
    .active_space_o(active_space), .status_o(status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow copy of the engine state.
  logic [63:0] mirror_heap [2*cgc_pkg::HeapWords];
  logic [63:0] mirror_roots [cgc_pkg::RootSlots];
  logic        mirror_live;
  logic [16:0] mirror_free;
  int          copy_alloc;
  bit          copy_ovf;

  gc_res_t     result_q [$];
  beat_t       typed_q [$];
  int          errors;
  bit          drv_live;
  int          beats_sent;
  bit          hold_req;

  // Space 0 holds byte addresses 0 to 32767, space 1 the next 32768.
  function automatic bit in_from_space(logic [63:0] a, logic sp);
    return (a[63:16] == '0) && (a[15] == sp);
  endfunction

  // Copies one tuple into tospace if it fits and returns the new value of the
  // referring word. A tag with bit 0 set already holds the address of the copy.
  function automatic logic [63:0] evacuate(logic [63:0] addr, int from_end, int to_end);
    int src, words, dest;
    logic [63:0] tag;
    src = int'(addr >> 3);
    tag = mirror_heap[src];
    if (tag[0]) return tag & ~64'd1;
    words = int'(tag[6:1]) + 1;
    if (copy_alloc + words > to_end) begin
      copy_ovf = 1'b1;
      return addr;
    end
    dest = copy_alloc;
    for (int k = 0; k < words; k++)
      mirror_heap[dest + k] = (src + k < from_end) ? mirror_heap[src + k] : 64'd0;
    copy_alloc = dest + words;
    mirror_heap[src] = (64'(dest) << 3) | 64'd1;
    return 64'(dest) << 3;
  endfunction

  // Cheney pass: roots first, then a breadth-first scan of tospace.
  function automatic bit collect_mirror(logic [8:0] rc);
    int from_base, to_base, scan, cnt, len, idx;
    logic [63:0] tag, v;
    from_base = mirror_live ? cgc_pkg::HeapWords : 0;
    to_base = mirror_live ? 0 : cgc_pkg::HeapWords;
    copy_alloc = to_base;
    copy_ovf = 1'b0;
    scan = to_base;
    cnt = (rc > cgc_pkg::RootSlots) ? cgc_pkg::RootSlots : int'(rc);
    for (int r = 0; r < cnt && !copy_ovf; r++) begin
      v = mirror_roots[r];
      if (v != 0 && in_from_space(v, mirror_live))
        mirror_roots[r] = evacuate(v, from_base + cgc_pkg::HeapWords,
                                   to_base + cgc_pkg::HeapWords);
    end
    while (!copy_ovf && scan < copy_alloc) begin
      tag = mirror_heap[scan];
      len = int'(tag[6:1]);
      // Mask bits past bit 63 do not exist, so elements from 57 on are data.
      for (int i = 0; i < len && i <= 56 && !copy_ovf; i++) begin
        if (tag[7 + i]) begin
          idx = scan + 1 + i;
          v = mirror_heap[idx];
          if (in_from_space(v, mirror_live))
            mirror_heap[idx] = evacuate(v, from_base + cgc_pkg::HeapWords,
                                        to_base + cgc_pkg::HeapWords);
        end
      end
      scan += len + 1;
    end
    for (int w = 0; w < cgc_pkg::HeapWords; w++) mirror_heap[from_base + w] = 64'd0;
    mirror_live = ~mirror_live;
    mirror_free = 17'(copy_alloc * 8);
    return copy_ovf;
  endfunction

  function automatic gc_res_t apply_command(beat_t b);
    gc_res_t r;
    r = '0;
    case (b.cmd)
      cgc_pkg::CMD_WR_HEAP: mirror_heap[b.hw] = b.wv;
      cgc_pkg::CMD_RD_HEAP: r.rd = mirror_heap[b.hw];
      cgc_pkg::CMD_WR_ROOT: mirror_roots[b.rs] = b.wv;
      cgc_pkg::CMD_RD_ROOT: r.rd = mirror_roots[b.rs];
      cgc_pkg::CMD_COLLECT: r.st = collect_mirror(b.rc);
      default: ;
    endcase
    r.fa = mirror_free;
    r.sp = mirror_live;
    return r;
  endfunction

  // Every accepted command beat yields exactly one result beat.
  always @(posedge clk) begin
    beat_t b, t;
    gc_res_t r;
    if (rst_n && in_valid && !in_stall) begin
      b = '{cmd: cmd, hw: heap_word, rs: root_slot, rc: root_count, wv: write_value,
            typed: 1'b0, res: '0};
      r = apply_command(b);
      t = typed_q.pop_front();
      result_q.push_back(t.typed ? t.res : r);
    end
  end

  always @(posedge clk) begin
    gc_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = result_q.pop_front();
        if (read_value !== e.rd) begin
          $error("read_value: expected %h, got %h", e.rd, read_value);
          errors++;
        end
        if (free_address !== e.fa) begin
          $error("free_address: expected %h, got %h", e.fa, free_address);
          errors++;
        end
        if (active_space !== e.sp) begin
          $error("active_space: expected %b, got %b", e.sp, active_space);
          errors++;
        end
        if (status !== e.st) begin
          $error("status: expected %b, got %b", e.st, status);
          errors++;
        end
      end
    end
  end

  // Result side back-pressure: calm stretches, short and long stalls, and one
  // long hold on request so that the command side backs up.
  initial begin
    int left, calm;
    left = 0;
    calm = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 199) == 0) calm = $urandom_range(50, 300);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else if (calm > 0) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: begin
            left = $urandom_range(0, 2);
            out_stall <= 1'b1;
          end
          4: begin
            left = $urandom_range(10, 40);
            out_stall <= 1'b1;
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Presents one beat, holds it until taken, then sometimes idles a random while.
  // Called at a rising edge, returns at one.
  task automatic send_beat(beat_t b);
    int gap;
    typed_q.push_back(b);
    in_valid <= 1'b1;
    cmd <= b.cmd;
    heap_word <= b.hw;
    root_slot <= b.rs;
    root_count <= b.rc;
    write_value <= b.wv;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (b.cmd == cgc_pkg::CMD_COLLECT) drv_live = ~drv_live;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: gap = $urandom_range(1, 3);
      4: gap = $urandom_range(10, 40);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic beat_t mk(logic [2:0] c, logic [12:0] hw, logic [7:0] rs,
                               logic [8:0] rc, logic [63:0] wv);
    return '{cmd: c, hw: hw, rs: rs, rc: rc, wv: wv, typed: 1'b0, res: '0};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Builds a handful of tuples in the live space, points some roots at them,
  // collects, and reads back part of the result.
  task automatic graph_episode();
    int n, k, base, pos [8], len [8];
    logic [63:0] tag, v, mask;
    n = $urandom_range(1, 8);
    base = (drv_live ? cgc_pkg::HeapWords : 0) + $urandom_range(0, 3500);
    for (int i = 0; i < n; i++) begin
      len[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 63) : $urandom_range(0, 6);
      pos[i] = (i == 0) ? base : pos[i-1] + len[i-1] + 1 + $urandom_range(0, 3);
    end
    for (int i = 0; i < n; i++) begin
      mask = '0;
      for (int e = 0; e < len[i] && e < 57; e++) mask[e] = $urandom_range(0, 1);
      tag = (mask << 7) | (64'(len[i]) << 1);
      // Now and then a tag that already looks forwarded.
      if ($urandom_range(0, 15) == 0) tag = (64'($urandom_range(0, 8191)) << 3) | 64'd1;
      send_beat(mk(cgc_pkg::CMD_WR_HEAP, 13'(pos[i]), 0, 0, tag));
      for (int e = 0; e < len[i]; e++) begin
        if (mask[e] && $urandom_range(0, 7) != 0)
          v = (64'(pos[$urandom_range(0, n-1)]) << 3) +
              (($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 7)) : 64'd0);
        else
          v = rand64();
        send_beat(mk(cgc_pkg::CMD_WR_HEAP, 13'(pos[i] + 1 + e), 0, 0, v));
      end
    end
    k = $urandom_range(1, 6);
    for (int r = 0; r < k; r++) begin
      case ($urandom_range(0, 5))
        0: v = 64'd0;
        1: v = rand64();
        default: v = 64'(pos[$urandom_range(0, n-1)]) << 3;
      endcase
      send_beat(mk(cgc_pkg::CMD_WR_ROOT, 0, 8'(r), 0, v));
    end
    send_beat(mk(cgc_pkg::CMD_COLLECT, 0, 0,
                 ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511)) : 9'(k), 0));
    for (int j = 0; j < 3; j++) begin
      send_beat(mk(cgc_pkg::CMD_RD_ROOT, 0, 8'($urandom_range(0, k-1)), 0, 0));
      send_beat(mk(cgc_pkg::CMD_RD_HEAP, {drv_live, 12'($urandom_range(0, 40))}, 0, 0, 0));
    end
  endtask

  // Seventy tuples of 64 words each cannot all fit into one semispace.
  task automatic overflow_episode();
    int base;
    base = drv_live ? cgc_pkg::HeapWords : 0;
    hold_req = 1'b1;
    for (int i = 0; i < 70; i++) begin
      send_beat(mk(cgc_pkg::CMD_WR_HEAP, 13'(base + i*58), 0, 0, 64'd63 << 1));
      send_beat(mk(cgc_pkg::CMD_WR_ROOT, 0, 8'(i), 0, 64'(base + i*58) << 3));
    end
    send_beat(mk(cgc_pkg::CMD_COLLECT, 0, 0, 9'd70, 0));
  endtask

  // Directed table; rows with typed set carry an expectation written by hand.
  localparam int DirRows = 25;
  beat_t dir_tbl [DirRows] = '{
    '{cgc_pkg::CMD_RD_HEAP, 13'd0, 8'd0, 9'd0, 64'd0, 1'b1, '{64'd0, 17'd0, 1'b0, 1'b0}},
    '{cgc_pkg::CMD_RD_HEAP, 13'd8191, 8'd0, 9'd0, 64'd0, 1'b1, '{64'd0, 17'd0, 1'b0, 1'b0}},
    '{cgc_pkg::CMD_RD_ROOT, 13'd0, 8'd255, 9'd0, 64'd0, 1'b1, '{64'd0, 17'd0, 1'b0, 1'b0}},
    '{CmdRsvdFirst, 13'd8191, 8'd255, 9'd511, '1, 1'b1, '{64'd0, 17'd0, 1'b0, 1'b0}},
    '{CmdRsvdLast, 13'd0, 8'd0, 9'd0, MaxPos, 1'b1, '{64'd0, 17'd0, 1'b0, 1'b0}},
    '{cgc_pkg::CMD_WR_HEAP, 13'd8191, 8'd0, 9'd0, MaxPos, 1'b0, '0},
    '{cgc_pkg::CMD_RD_HEAP, 13'd8191, 8'd0, 9'd0, 64'd0, 1'b1, '{MaxPos, 17'd0, 1'b0, 1'b0}},
    '{cgc_pkg::CMD_WR_ROOT, 13'd0, 8'd255, 9'd0, MinNeg, 1'b0, '0},
    '{cgc_pkg::CMD_RD_ROOT, 13'd0, 8'd255, 9'd0, 64'd0, 1'b1, '{MinNeg, 17'd0, 1'b0, 1'b0}},
    // Two-element tuple whose first element points at a one-element tuple.
    '{cgc_pkg::CMD_WR_HEAP, 13'd0, 8'd0, 9'd0, 64'h84, 1'b0, '0},
    '{cgc_pkg::CMD_WR_HEAP, 13'd1, 8'd0, 9'd0, 64'd80, 1'b0, '0},
    '{cgc_pkg::CMD_WR_HEAP, 13'd2, 8'd0, 9'd0, MinNeg, 1'b0, '0},
    '{cgc_pkg::CMD_WR_HEAP, 13'd10, 8'd0, 9'd0, 64'd2, 1'b0, '0},
    '{cgc_pkg::CMD_WR_HEAP, 13'd11, 8'd0, 9'd0, MaxPos, 1'b0, '0},
    // Tuple running past the end of the space, and one with a full mask.
    '{cgc_pkg::CMD_WR_HEAP, 13'd4095, 8'd0, 9'd0, 64'h8A, 1'b0, '0},
    '{cgc_pkg::CMD_WR_HEAP, 13'd20, 8'd0, 9'd0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
    // Unaligned root, shared reference, root to the tuple past the end, unaligned root to the full-mask one.
    '{cgc_pkg::CMD_WR_ROOT, 13'd0, 8'd0, 9'd0, 64'd3, 1'b0, '0},
    '{cgc_pkg::CMD_WR_ROOT, 13'd0, 8'd1, 9'd0, 64'd80, 1'b0, '0},
    '{cgc_pkg::CMD_WR_ROOT, 13'd0, 8'd2, 9'd0, 64'd32760, 1'b0, '0},
    '{cgc_pkg::CMD_WR_ROOT, 13'd0, 8'd3, 9'd0, 64'd165, 1'b0, '0},
    '{cgc_pkg::CMD_COLLECT, 13'd0, 8'd0, 9'd511, 64'd0, 1'b0, '0},
    '{cgc_pkg::CMD_RD_ROOT, 13'd0, 8'd0, 9'd0, 64'd0, 1'b0, '0},
    '{cgc_pkg::CMD_RD_HEAP, 13'd4096, 8'd0, 9'd0, 64'd0, 1'b0, '0},
    // Collect with no roots empties the heap and swaps back.
    '{cgc_pkg::CMD_COLLECT, 13'd0, 8'd0, 9'd0, 64'd0, 1'b1, '{64'd0, 17'd0, 1'b0, 1'b0}},
    '{cgc_pkg::CMD_RD_HEAP, 13'd4096, 8'd0, 9'd0, 64'd0, 1'b1, '{64'd0, 17'd0, 1'b0, 1'b0}}
  };

  initial begin
    bit overflow_done;
    for (int w = 0; w < 2*cgc_pkg::HeapWords; w++) mirror_heap[w] = '0;
    for (int r = 0; r < cgc_pkg::RootSlots; r++) mirror_roots[r] = '0;
    mirror_live = 1'b0;
    mirror_free = '0;
    errors = 0;
    drv_live = 1'b0;
    beats_sent = 0;
    hold_req = 1'b0;
    overflow_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    cmd = cgc_pkg::CMD_RD_HEAP;
    heap_word = '0;
    root_slot = '0;
    root_count = '0;
    write_value = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_beat(dir_tbl[i]);

    while (beats_sent < TargetBeats) begin
      if (!overflow_done && beats_sent > 350) begin
        overflow_episode();
        overflow_done = 1'b1;
      end else if ($urandom_range(0, 9) < 6) begin
        graph_episode();
      end else begin
        // Noise: any command, any field value.
        repeat (10)
          send_beat(mk(3'($urandom_range(0, 7)), 13'($urandom()), 8'($urandom()),
                       9'($urandom()), rand64()));
      end
    end

    in_valid <= 1'b0;
    while (result_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- copying_garbage_collector.f -----
+incdir+rtl
rtl/cgc_pkg.sv
rtl/cgc_ram.sv
rtl/copying_garbage_collector.sv
verif/tb_copying_garbage_collector.sv
